/* src/kws_pkg.sv */
// Shared types and constants of the kerned string width block.
package kws_pkg;

   localparam int CHAR_CODES_DEFAULT = 256;
   localparam int KERN_SLOTS_DEFAULT = 64;
   localparam int ACC_BITS_DEFAULT   = 24;

   localparam int CODE_BITS    = 8;
   localparam int CODE_SPACE   = 2 ** CODE_BITS;
   localparam int GWIDTH_BITS  = 10;
   localparam int KVALUE_BITS  = 8;
   localparam int SLOT_BITS    = 6;
   localparam int SLOT_SPACE   = 2 ** SLOT_BITS;
   localparam int SPACING_BITS = 7;
   localparam int SCALE_BITS   = 16;
   localparam int OUT_BITS     = 24;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd256;

   typedef enum logic [1:0] {
      OP_DEFINE_GLYPH = 2'd0,
      OP_WRITE_KERN   = 2'd1,
      OP_CHAR         = 2'd2,
      OP_END          = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_CHAR_SPACING = 1'b0,
      CSR_SCALE_Q8     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ARITH_NOP,
      ARITH_ADD_KERN,
      ARITH_ADD_GLYPH,
      ARITH_SCALE,
      ARITH_CLEAR
   } arith_op_type;

   typedef struct packed {
      opcode_type                     opcode;
      logic [CODE_BITS-1:0]           char_code;
      logic [GWIDTH_BITS-1:0]         glyph_width;
      logic [CODE_BITS-1:0]           kern_next_code;
      logic signed [KVALUE_BITS-1:0]  kern_value;
      logic [SLOT_BITS-1:0]           kern_slot;
   } req_word_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]          prev_code;
      logic [CODE_BITS-1:0]          next_code;
      logic signed [KVALUE_BITS-1:0] value;
   } kern_entry_type;

   typedef struct packed {
      arith_op_type                  op;
      logic signed [KVALUE_BITS-1:0] kern_value;
      logic [GWIDTH_BITS-1:0]        glyph_width;
   } arith_cmd_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] string_width;
      logic                       width_saturated;
   } result_type;

endpackage

/* src/kws_req_if.sv */
// Request channel: glyph, kerning and string commands.
interface kws_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                opcode;
   logic [kws_pkg::CODE_BITS-1:0]             char_code;
   logic [kws_pkg::GWIDTH_BITS-1:0]           glyph_width;
   logic [kws_pkg::CODE_BITS-1:0]             kern_next_code;
   logic signed [kws_pkg::KVALUE_BITS-1:0]    kern_value;
   logic [kws_pkg::SLOT_BITS-1:0]             kern_slot;

   modport source (output valid, opcode, char_code, glyph_width, kern_next_code,
                   kern_value, kern_slot, input ready);
   modport sink (input valid, opcode, char_code, glyph_width, kern_next_code,
                 kern_value, kern_slot, output ready);
endinterface

/* src/kws_rsp_if.sv */
// Response channel: measured string width.
interface kws_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [kws_pkg::OUT_BITS-1:0]    string_width;
   logic                                   width_saturated;

   modport source (output valid, string_width, width_saturated, input ready);
   modport sink (input valid, string_width, width_saturated, output ready);
endinterface

/* src/kws_ram.sv */
// Generic single write port, single read port RAM with registered read.
module kws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kws_arith.sv */
// Shared saturating accumulator and final scale unit.
module kws_arith #(
   parameter int ACC_BITS = kws_pkg::ACC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  kws_pkg::arith_cmd_type                   cmd,
   input  logic signed [kws_pkg::SPACING_BITS-1:0]  char_spacing,
   input  logic [kws_pkg::SCALE_BITS-1:0]           scale_q8,
   output kws_pkg::result_type                      result
);

   localparam int DELTA_BITS = 12;
   localparam int PW = ACC_BITS + kws_pkg::SCALE_BITS + 1;
   localparam int QW = (PW - 8 > kws_pkg::OUT_BITS + 1) ? PW - 8 : kws_pkg::OUT_BITS + 1;
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [QW-1:0] OUT_MAX = QW'((2 ** (kws_pkg::OUT_BITS - 1)) - 1);
   localparam logic signed [QW-1:0] OUT_MIN = -QW'(2 ** (kws_pkg::OUT_BITS - 1));

   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                         clamp_ff, clamp_in;
   logic signed [PW-1:0]         product_ff, product_in;
   logic signed [DELTA_BITS-1:0] delta;
   logic signed [ACC_BITS:0]     sum;
   logic                         sum_ovf;
   logic signed [ACC_BITS-1:0]   sum_sat;
   logic signed [kws_pkg::SCALE_BITS:0] scale_s;
   logic [PW-1:0]                round_adj;
   logic [PW-1:0]                adjusted;
   logic signed [PW-9:0]         quotient;
   logic signed [QW-1:0]         q_wide;
   logic                         out_clamp;

   always_comb begin
      if (cmd.op == kws_pkg::ARITH_ADD_KERN) begin
         delta = DELTA_BITS'(cmd.kern_value);
      end else begin
         delta = $signed({2'b00, cmd.glyph_width}) + DELTA_BITS'(char_spacing);
      end
      sum     = {acc_ff[ACC_BITS-1], acc_ff}
                + {{(ACC_BITS + 1 - DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
      sum_ovf = sum[ACC_BITS] != sum[ACC_BITS-1];
      if (sum_ovf) begin
         sum_sat = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum[ACC_BITS-1:0];
      end
   end

   assign scale_s = $signed({1'b0, scale_q8});

   always_comb begin
      acc_in     = acc_ff;
      clamp_in   = clamp_ff;
      product_in = product_ff;
      unique case (cmd.op)
         kws_pkg::ARITH_NOP: begin
         end
         kws_pkg::ARITH_ADD_KERN, kws_pkg::ARITH_ADD_GLYPH: begin
            acc_in   = sum_sat;
            clamp_in = clamp_ff | sum_ovf;
         end
         kws_pkg::ARITH_SCALE: begin
            product_in = acc_ff * scale_s;
         end
         kws_pkg::ARITH_CLEAR: begin
            acc_in   = '0;
            clamp_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // divide by 256 rounding toward zero
   always_comb begin
      round_adj = product_ff[PW-1] ? PW'(255) : '0;
      adjusted  = product_ff + round_adj;
      quotient  = $signed(adjusted[PW-1:8]);
      q_wide    = QW'(quotient);
      out_clamp = 1'b0;
      if (q_wide > OUT_MAX) begin
         result.string_width = OUT_MAX[kws_pkg::OUT_BITS-1:0];
         out_clamp           = 1'b1;
      end else if (q_wide < OUT_MIN) begin
         result.string_width = OUT_MIN[kws_pkg::OUT_BITS-1:0];
         out_clamp           = 1'b1;
      end else begin
         result.string_width = q_wide[kws_pkg::OUT_BITS-1:0];
      end
      result.width_saturated = clamp_ff | out_clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         clamp_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         clamp_ff <= clamp_in;
      end
      product_ff <= product_in;
   end

endmodule

/* src/kws_seq.sv */
// Command sequencer with glyph and kerning stores and the kerning slot scan.
module kws_seq #(
   parameter int CHAR_CODES = kws_pkg::CHAR_CODES_DEFAULT,
   parameter int KERN_SLOTS = kws_pkg::KERN_SLOTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  kws_pkg::req_word_type  req_word,
   output logic                   req_ready,
   input  logic                   out_free,
   output kws_pkg::arith_cmd_type cmd,
   output logic                   rsp_load
);

   localparam int GDEPTH    = (CHAR_CODES < kws_pkg::CODE_SPACE) ? CHAR_CODES
                                                                  : kws_pkg::CODE_SPACE;
   localparam int GIDX_BITS = $clog2(GDEPTH);
   localparam int KDEPTH    = (KERN_SLOTS < kws_pkg::SLOT_SPACE) ? KERN_SLOTS
                                                                  : kws_pkg::SLOT_SPACE;
   localparam int KIDX_BITS = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int CNT_BITS  = $clog2(KDEPTH + 1);
   localparam int KENT_BITS = $bits(kws_pkg::kern_entry_type);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_SCAN      = 5'b00010,
      S_GLYPH_ADD = 5'b00100,
      S_SCALE     = 5'b01000,
      S_FINISH    = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CNT_BITS-1:0]             cnt_ff, cnt_in;
   logic [kws_pkg::CODE_BITS-1:0]   code_ff, code_in;
   logic [kws_pkg::CODE_BITS-1:0]   prev_ff, prev_in;
   logic                            have_prev_ff, have_prev_in;
   logic                            kvld_ff, kvld_in;
   logic [GDEPTH-1:0]               glyph_def_ff, glyph_def_in;
   logic [KDEPTH-1:0]               kvalid_ff, kvalid_in;

   logic                            accept;
   logic                            code_in_range;
   logic                            slot_in_range;
   logic [GIDX_BITS-1:0]            glyph_idx;
   logic [KIDX_BITS-1:0]            slot_idx;
   logic [KIDX_BITS-1:0]            scan_addr;
   logic                            glyph_we, glyph_re, kern_we, kern_re;
   logic [kws_pkg::GWIDTH_BITS-1:0] glyph_rd;
   logic [KENT_BITS-1:0]            kern_rd_bits;
   kws_pkg::kern_entry_type         kern_rd;
   kws_pkg::kern_entry_type         kern_wr;
   logic                            hit;

   assign req_ready     = state_ff == S_IDLE;
   assign accept        = req_valid && req_ready;
   assign code_in_range = 32'(req_word.char_code) < CHAR_CODES;
   assign slot_in_range = 32'(req_word.kern_slot) < KERN_SLOTS;
   assign glyph_idx     = req_word.char_code[GIDX_BITS-1:0];
   assign slot_idx      = req_word.kern_slot[KIDX_BITS-1:0];
   assign scan_addr     = cnt_ff[KIDX_BITS-1:0];
   assign kern_rd       = kws_pkg::kern_entry_type'(kern_rd_bits);
   assign kern_wr       = '{prev_code: req_word.char_code,
                            next_code: req_word.kern_next_code,
                            value:     req_word.kern_value};

   kws_ram #(
      .WIDTH (kws_pkg::GWIDTH_BITS),
      .DEPTH (GDEPTH)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (glyph_idx),
      .wr_data (req_word.glyph_width),
      .rd_en   (glyph_re),
      .rd_addr (glyph_idx),
      .rd_data (glyph_rd)
   );

   kws_ram #(
      .WIDTH (KENT_BITS),
      .DEPTH (KDEPTH)
   ) u_kern_ram (
      .clock   (clock),
      .wr_en   (kern_we),
      .wr_addr (slot_idx),
      .wr_data (kern_wr),
      .rd_en   (kern_re),
      .rd_addr (scan_addr),
      .rd_data (kern_rd_bits)
   );

   // read data of the slot issued last cycle is compared now
   assign hit = (cnt_ff != '0) && kvld_ff && (kern_rd.prev_code == prev_ff)
                && (kern_rd.next_code == code_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      code_in      = code_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      kvld_in      = kvld_ff;
      glyph_def_in = glyph_def_ff;
      kvalid_in    = kvalid_ff;
      glyph_we     = 1'b0;
      glyph_re     = 1'b0;
      kern_we      = 1'b0;
      kern_re      = 1'b0;
      rsp_load     = 1'b0;
      cmd          = '{op: kws_pkg::ARITH_NOP, kern_value: kern_rd.value,
                       glyph_width: glyph_rd};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_word.opcode)
                  kws_pkg::OP_DEFINE_GLYPH: begin
                     if (code_in_range) begin
                        glyph_we                = 1'b1;
                        glyph_def_in[glyph_idx] = 1'b1;
                     end
                  end
                  kws_pkg::OP_WRITE_KERN: begin
                     if (slot_in_range) begin
                        kern_we             = 1'b1;
                        kvalid_in[slot_idx] = 1'b1;
                     end
                  end
                  kws_pkg::OP_CHAR: begin
                     // unknown glyphs are dropped here and leave the string alone
                     if (code_in_range && glyph_def_ff[glyph_idx]) begin
                        glyph_re = 1'b1;
                        code_in  = req_word.char_code;
                        cnt_in   = '0;
                        state_in = have_prev_ff ? S_SCAN : S_GLYPH_ADD;
                     end
                  end
                  kws_pkg::OP_END: begin
                     state_in = S_SCALE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            kern_re = 1'b1;
            kvld_in = (32'(cnt_ff) < KDEPTH) && kvalid_ff[scan_addr];
            if (hit) begin
               cmd.op   = kws_pkg::ARITH_ADD_KERN;
               state_in = S_GLYPH_ADD;
            end else if (cnt_ff == CNT_BITS'(KDEPTH)) begin
               state_in = S_GLYPH_ADD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_GLYPH_ADD: begin
            cmd.op       = kws_pkg::ARITH_ADD_GLYPH;
            prev_in      = code_ff;
            have_prev_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCALE: begin
            cmd.op   = kws_pkg::ARITH_SCALE;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op       = kws_pkg::ARITH_CLEAR;
               rsp_load     = 1'b1;
               prev_in      = '0;
               have_prev_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         glyph_def_ff <= '0;
         kvalid_ff    <= '0;
         cnt_ff       <= '0;
         kvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         glyph_def_ff <= glyph_def_in;
         kvalid_ff    <= kvalid_in;
         cnt_ff       <= cnt_in;
         kvld_ff      <= kvld_in;
      end
      code_ff <= code_in;
   end

endmodule

/* src/kerned_string_width.sv */
// Kerned string width measurement: top level with registers and output stage.
//
// Commands arrive one word at a time. Glyph definitions, kerning slot writes
// and characters with no defined glyph are handled in the idle state alone.
// A known character that opens a string goes to the glyph add state; after a
// known glyph it first goes through the scan state, because the kerning memory
// is scanned one slot per cycle through its single read port and the scan
// stops at the first matching slot. An end-of-string word goes through the
// scale state (multiply by scale_q8), then the finish state (divide, clamp
// and output register load), which waits while an earlier width is not taken.
// The next word is accepted while a finished width sits in the output register.
module kerned_string_width #(
   parameter int CHAR_CODES = kws_pkg::CHAR_CODES_DEFAULT,
   parameter int KERN_SLOTS = kws_pkg::KERN_SLOTS_DEFAULT,
   parameter int ACC_BITS   = kws_pkg::ACC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   kws_req_if.sink                             req_ch,
   kws_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [kws_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic signed [kws_pkg::SPACING_BITS-1:0] char_spacing_ff;
   logic [kws_pkg::SCALE_BITS-1:0]          scale_q8_ff;
   logic                                    rsp_valid_ff;
   kws_pkg::result_type                     rsp_word_ff;

   kws_pkg::req_word_type  req_word;
   kws_pkg::arith_cmd_type cmd;
   kws_pkg::result_type    result;
   logic                   out_free;
   logic                   rsp_load;

   assign req_word = '{opcode:         kws_pkg::opcode_type'(req_ch.opcode),
                       char_code:      req_ch.char_code,
                       glyph_width:    req_ch.glyph_width,
                       kern_next_code: req_ch.kern_next_code,
                       kern_value:     req_ch.kern_value,
                       kern_slot:      req_ch.kern_slot};

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   kws_seq #(
      .CHAR_CODES (CHAR_CODES),
      .KERN_SLOTS (KERN_SLOTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_word  (req_word),
      .req_ready (req_ch.ready),
      .out_free  (out_free),
      .cmd       (cmd),
      .rsp_load  (rsp_load)
   );

   kws_arith #(
      .ACC_BITS (ACC_BITS)
   ) u_arith (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .char_spacing (char_spacing_ff),
      .scale_q8     (scale_q8_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         char_spacing_ff <= '0;
         scale_q8_ff     <= kws_pkg::SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (kws_pkg::csr_index_type'(csr_index))
            kws_pkg::CSR_CHAR_SPACING: begin
               char_spacing_ff <= csr_data[kws_pkg::SPACING_BITS-1:0];
            end
            kws_pkg::CSR_SCALE_Q8: begin
               scale_q8_ff <= csr_data[kws_pkg::SCALE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // output stage: one word held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.string_width    = rsp_word_ff.string_width;
   assign rsp_ch.width_saturated = rsp_word_ff.width_saturated;

endmodule
